### design/cubic_fit_gradient_descent_defines.svh
// Assertion macros shared by the cubic fit design files.
`ifndef CUBIC_FIT_GRADIENT_DESCENT_DEFINES_SVH
`define CUBIC_FIT_GRADIENT_DESCENT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFGD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CFGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### design/cfgd_pkg.sv
// Types, constants and saturation functions of the cubic fit block.
package cfgd_pkg;

	localparam int SMP_W      = 16;
	localparam int RATE_W     = 16;
	localparam int COEF_W     = 32;
	localparam int SUM_W      = 48;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_COEF   = 4;
	localparam int K_W        = $clog2(NUM_COEF);

	// Fraction alignment shifts
	localparam int SH_CUBE = 16;  // x^3 in Q12.20
	localparam int SH_X    = 12;  // term times x
	localparam int SH_X2   = 24;  // term times x^2
	localparam int SH_X3   = 20;  // term times x^3
	localparam int SH_RATE = 16;  // err times rate
	localparam int SH_Y    = 4;   // Q4.12 to Q16.16

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(64);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT3 = 3'd5;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic MODE_STOCH = 1'b0;
	localparam logic MODE_BATCH = 1'b1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [NUM_COEF-1:0] coef_arr_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [SUM_W:0] wide_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X2,
		ST_X3,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_ERR,
		ST_RATE,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_STEP,
		UPD_SUM,
		UPD_FOLD,
		UPD_LOAD
	} upd_op_t;

	typedef struct packed {
		upd_op_t          op;
		logic [K_W-1:0]   k;
		sum_t             delta;
	} upd_cmd_t;

	// Clamp a wide value to the signed coefficient range.
	function automatic coef_t sat_coef(input wide_t v);
		coef_t r;
		if (v[SUM_W] && !(&v[SUM_W-1:COEF_W-1]))
			r = {1'b1, {(COEF_W-1){1'b0}}};
		else if (!v[SUM_W] && (|v[SUM_W-1:COEF_W-1]))
			r = {1'b0, {(COEF_W-1){1'b1}}};
		else
			r = v[COEF_W-1:0];
		return r;
	endfunction

	// Clamp a wide value to the signed sum range.
	function automatic sum_t sat_sum(input wide_t v);
		sum_t r;
		if (v[SUM_W] != v[SUM_W-1])
			r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			r = v[SUM_W-1:0];
		return r;
	endfunction

endpackage

### design/cfgd_sample_if.sv
// Sample request channel of the cubic fit block.
interface cfgd_sample_if;
	import cfgd_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [SMP_W-1:0]  x_sample;
	logic [SMP_W-1:0]  y_sample;
	logic              pass_end;

	modport source (output valid, opcode, x_sample, y_sample, pass_end, input ready);
	modport sink (input valid, opcode, x_sample, y_sample, pass_end, output ready);
endinterface

### design/cfgd_result_if.sv
// Result channel of the cubic fit block.
interface cfgd_result_if;
	import cfgd_pkg::*;

	logic               valid;
	logic               ready;
	logic [COEF_W-1:0]  coef0;
	logic [COEF_W-1:0]  coef1;
	logic [COEF_W-1:0]  coef2;
	logic [COEF_W-1:0]  coef3;
	logic               applied;

	modport source (output valid, coef0, coef1, coef2, coef3, applied, input ready);
	modport sink (input valid, coef0, coef1, coef2, coef3, applied, output ready);
endinterface

### design/cfgd_cfg_if.sv
// Register write channel of the cubic fit block.
interface cfgd_cfg_if;
	import cfgd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/cubic_fit_gradient_descent.sv
// Top level of the cubic fit block: sequencer, datapath registers and ports.
//
// Fits y = c3*x^3 + c2*x^2 + c1*x + c0 by gradient descent, one (x, y) sample per
// request, and returns the four Q16.16 coefficients after every request. All
// multiplication runs through one 32x32 signed multiplier that is used nine times
// in series per sample (x^2, x^3, three prediction terms, err*rate, three
// update terms); a sample that ends a batch pass adds a fold step in which the
// sums are folded in, and a restart request goes straight to the output step.
// The sample port is ready only while the sequencer is idle. Results sit in an
// output register, so a new request is taken while the previous result still
// waits; a finished item holds in its last step until that register is free.
// Register writes are taken at any time and belong between requests; initial
// coefficients take effect at the next restart.
`include "cubic_fit_gradient_descent_defines.svh"

module cubic_fit_gradient_descent (
	input  logic       clk,
	input  logic       arst_n,
	cfgd_cfg_if.sink   cfg,
	cfgd_sample_if.sink sample,
	cfgd_result_if.source result
);
	import cfgd_pkg::*;

	state_t              state_q, state_d;
	logic                mode_q;
	logic [RATE_W-1:0]   rate_q;
	coef_arr_t           init_q;

	logic signed [SMP_W-1:0]  x_q, y_q;
	logic                     pass_end_q;
	coef_t                    x2_q, x3_q, e_q;
	sum_t                     acc_q;
	logic                     changed_q;

	logic                     mul_en;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	upd_cmd_t                 cmd;
	coef_arr_t                coef;
	logic                     changed;

	logic                     out_valid_q;
	coef_arr_t                out_coef_q;
	logic                     out_applied_q;

	logic signed [PROD_W-1:0] prod_cube, prod_x, prod_x2, prod_x3, prod_rate;
	coef_t                    x_ext, err_c, e_c;
	logic                     accept, out_load;
	upd_op_t                  delta_op;

	assign prod_cube = prod >>> SH_CUBE;
	assign prod_x    = prod >>> SH_X;
	assign prod_x2   = prod >>> SH_X2;
	assign prod_x3   = prod >>> SH_X3;
	assign prod_rate = prod >>> SH_RATE;

	assign x_ext = coef_t'(x_q);
	assign e_c   = prod_rate[COEF_W-1:0];
	assign err_c = sat_coef((wide_t'(y_q) <<< SH_Y) - wide_t'(acc_q));

	assign delta_op = (mode_q == MODE_BATCH) ? UPD_SUM : UPD_STEP;
	assign accept   = sample.valid && sample.ready;
	assign cfg.ready = 1'b1;

	cfgd_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	cfgd_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.init    (init_q),
		.coef    (coef),
		.changed (changed)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOCH;
			rate_q <= RATE_RESET;
			init_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE:  mode_q <= cfg.data[0];
				REG_RATE:  rate_q <= cfg.data[RATE_W-1:0];
				REG_INIT0: init_q[0] <= cfg.data;
				REG_INIT1: init_q[1] <= cfg.data;
				REG_INIT2: init_q[2] <= cfg.data;
				REG_INIT3: init_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequence the shared multiplier and the update adder
	always_comb begin
		state_d      = state_q;
		mul_en       = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		cmd.op       = UPD_NONE;
		cmd.k        = '0;
		cmd.delta    = '0;
		sample.ready = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					if (sample.opcode == OP_RESTART) begin
						cmd.op  = UPD_LOAD;
						state_d = ST_OUT;
					end else begin
						state_d = ST_X2;
					end
				end
			end
			ST_X2: begin
				mul_en  = 1'b1;
				mul_a   = x_ext;
				mul_b   = x_ext;
				state_d = ST_X3;
			end
			ST_X3: begin
				mul_en  = 1'b1;
				mul_a   = prod[MUL_W-1:0];
				mul_b   = x_ext;
				state_d = ST_P1;
			end
			ST_P1: begin
				mul_en  = 1'b1;
				mul_a   = coef[1];
				mul_b   = x_ext;
				state_d = ST_P2;
			end
			ST_P2: begin
				mul_en  = 1'b1;
				mul_a   = coef[2];
				mul_b   = x2_q;
				state_d = ST_P3;
			end
			ST_P3: begin
				mul_en  = 1'b1;
				mul_a   = coef[3];
				mul_b   = x3_q;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				state_d = ST_RATE;
			end
			ST_RATE: begin
				mul_en  = 1'b1;
				mul_a   = err_c;
				mul_b   = coef_t'({1'b0, rate_q});
				state_d = ST_D0;
			end
			ST_D0: begin
				cmd.op    = delta_op;
				cmd.k     = K_W'(0);
				cmd.delta = sum_t'(e_c);
				mul_en    = 1'b1;
				mul_a     = e_c;
				mul_b     = x_ext;
				state_d   = ST_D1;
			end
			ST_D1: begin
				cmd.op    = delta_op;
				cmd.k     = K_W'(1);
				cmd.delta = prod_x[SUM_W-1:0];
				mul_en    = 1'b1;
				mul_a     = e_q;
				mul_b     = x2_q;
				state_d   = ST_D2;
			end
			ST_D2: begin
				cmd.op    = delta_op;
				cmd.k     = K_W'(2);
				cmd.delta = prod_x2[SUM_W-1:0];
				mul_en    = 1'b1;
				mul_a     = e_q;
				mul_b     = x3_q;
				state_d   = ST_D3;
			end
			ST_D3: begin
				cmd.op    = delta_op;
				cmd.k     = K_W'(3);
				cmd.delta = prod_x3[SUM_W-1:0];
				state_d   = (mode_q == MODE_BATCH && pass_end_q) ? ST_FOLD : ST_OUT;
			end
			ST_FOLD: begin
				cmd.op  = UPD_FOLD;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request and the intermediate terms
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= sample.x_sample;
			y_q        <= sample.y_sample;
			pass_end_q <= sample.pass_end;
		end
		case (state_q)
			ST_X3: x2_q <= prod[COEF_W-1:0];
			ST_P1: begin
				x3_q  <= prod_cube[COEF_W-1:0];
				acc_q <= sum_t'(coef[0]);
			end
			ST_P2:  acc_q <= acc_q + prod_x[SUM_W-1:0];
			ST_P3:  acc_q <= acc_q + prod_x2[SUM_W-1:0];
			ST_ERR: acc_q <= acc_q + prod_x3[SUM_W-1:0];
			ST_D0:  e_q <= e_c;
			default: ;
		endcase
	end

	// Track whether any coefficient moved on this request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (accept) begin
			changed_q <= changed;
		end else begin
			changed_q <= changed_q | changed;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_coef_q    <= coef;
			out_applied_q <= changed_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.coef0   = out_coef_q[0];
	assign result.coef1   = out_coef_q[1];
	assign result.coef2   = out_coef_q[2];
	assign result.coef3   = out_coef_q[3];
	assign result.applied = out_applied_q;

	`CFGD_ASSERT_NEXT(a_sample_starts, clk, arst_n, accept && (sample.opcode == OP_SAMPLE), state_q == ST_X2)
	`CFGD_ASSERT_NEXT(a_restart_to_out, clk, arst_n, accept && (sample.opcode == OP_RESTART), state_q == ST_OUT)
	`CFGD_ASSERT_NOW(a_fold_only_batch_end, clk, arst_n, state_q == ST_FOLD, (mode_q == MODE_BATCH) && pass_end_q)
	`CFGD_ASSERT_NEXT(a_out_load, clk, arst_n, out_load, result.valid && (result.applied == $past(changed_q)))
endmodule

### design/cfgd_mul.sv
// Shared signed 32x32 multiplier with registered product.
module cfgd_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [cfgd_pkg::MUL_W-1:0]   a,
	input  logic signed [cfgd_pkg::MUL_W-1:0]   b,
	output logic signed [cfgd_pkg::PROD_W-1:0]  prod_q
);
	import cfgd_pkg::*;

	// Capture the product when the sequencer issues a multiply
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end
endmodule

### design/cfgd_store.sv
// Coefficient and batch sum storage with a shared saturating update adder.
`include "cubic_fit_gradient_descent_defines.svh"

module cfgd_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfgd_pkg::upd_cmd_t     cmd,
	input  cfgd_pkg::coef_arr_t    init,
	output cfgd_pkg::coef_arr_t    coef,
	output logic                   changed
);
	import cfgd_pkg::*;

	coef_arr_t coef_q;
	sum_t      sum_q [NUM_COEF];
	coef_t     step_val;
	sum_t      sum_val;
	coef_arr_t fold_val;
	logic      fold_diff;
	logic      sums_zero;

	assign coef = coef_q;

	// Flag all batch sums at zero
	assign sums_zero = (sum_q[0] == '0) && (sum_q[1] == '0) && (sum_q[2] == '0)
		&& (sum_q[3] == '0);

	// Add one delta to the selected coefficient or sum, and fold all sums in parallel
	always_comb begin
		step_val  = sat_coef(wide_t'(coef_q[cmd.k]) + wide_t'(cmd.delta));
		sum_val   = sat_sum(wide_t'(sum_q[cmd.k]) + wide_t'(cmd.delta));
		fold_diff = 1'b0;
		for (int i = 0; i < NUM_COEF; i++) begin
			fold_val[i] = sat_coef(wide_t'(coef_q[i]) + wide_t'(sum_q[i]));
			fold_diff   = fold_diff | (fold_val[i] != coef_q[i]);
		end
	end

	// Report whether this command moves any coefficient
	always_comb begin
		case (cmd.op)
			UPD_STEP: changed = (step_val != coef_q[cmd.k]);
			UPD_FOLD: changed = fold_diff;
			UPD_LOAD: changed = (init != coef_q);
			default:  changed = 1'b0;
		endcase
	end

	// Apply the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			for (int i = 0; i < NUM_COEF; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			case (cmd.op)
				UPD_STEP: coef_q[cmd.k] <= step_val;
				UPD_SUM:  sum_q[cmd.k] <= sum_val;
				UPD_FOLD: begin
					coef_q <= fold_val;
					for (int i = 0; i < NUM_COEF; i++) begin
						sum_q[i] <= '0;
					end
				end
				UPD_LOAD: begin
					coef_q <= init;
					for (int i = 0; i < NUM_COEF; i++) begin
						sum_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	`CFGD_ASSERT_NEXT(a_load_clears_sums, clk, arst_n, cmd.op == UPD_LOAD, sums_zero)
	`CFGD_ASSERT_NEXT(a_fold_clears_sums, clk, arst_n, cmd.op == UPD_FOLD, sums_zero)
endmodule
